// ===== design/owm_pkg.sv =====
// shared types, register indexes and constants of the one-wire bus master
package owm_pkg;

    localparam int unsigned CFG_W           = 10;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam int unsigned TIMER_W         = 11;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned PHASE_W         = 3;
    localparam int unsigned BITCNT_W        = 4;
    localparam int unsigned IN_TDATA_W      = 16;
    localparam int unsigned OUT_TDATA_W     = 16;
    localparam int unsigned ACTION_W        = 2;

    localparam logic [TIMER_W-1:0]  TIMER_MAX         = 11'd2047;
    localparam logic [TIMER_W-1:0]  READ_LOW_TICKS    = 11'd6;
    localparam logic [BITCNT_W-1:0] BITS_PER_TRANSFER = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SLOT     = 3'd7;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RESET = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RLOW  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RWAIT = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RTAIL = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WRITE = 3'd4;
    localparam logic [PHASE_W-1:0] PH_READ  = 3'd5;

    typedef logic [CFG_W-1:0] cfg_word_t;

    typedef struct packed {
        cfg_word_t reset_low_time;
        cfg_word_t presence_wait;
        cfg_word_t reset_tail;
        cfg_word_t one_low_time;
        cfg_word_t zero_low_time;
        cfg_word_t write_slot_time;
        cfg_word_t read_sample_time;
        cfg_word_t read_slot_time;
    } owm_cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   write_byte;
        logic                line_level;
    } owm_item_t;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic [TIMER_W-1:0]  slot_timer;
        logic [BITCNT_W-1:0] bit_count;
        logic [BYTE_W-1:0]   shift_byte;
        logic                presence_seen;
        logic [BYTE_W-1:0]   read_hold;
    } owm_state_t;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_value;
        logic              presence;
        logic              rejected;
    } owm_result_t;

    // a zero timing register acts as one
    function automatic cfg_word_t eff(input cfg_word_t v);
        return (v == '0) ? cfg_word_t'(1) : v;
    endfunction

endpackage

// ===== design/owm_cfg_regs.sv =====
// timing register file of the one-wire bus master
module owm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [owm_pkg::CFG_IDX_W-1:0]  wr_index,
    input  owm_pkg::cfg_word_t             wr_data,
    output owm_pkg::owm_cfg_t              cfg
);
    import owm_pkg::*;

    owm_cfg_t cfg_reg;
    owm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_RESET_LOW:     cfg_next.reset_low_time   = wr_data;
                REG_PRESENCE_WAIT: cfg_next.presence_wait    = wr_data;
                REG_RESET_TAIL:    cfg_next.reset_tail       = wr_data;
                REG_ONE_LOW:       cfg_next.one_low_time     = wr_data;
                REG_ZERO_LOW:      cfg_next.zero_low_time    = wr_data;
                REG_WRITE_SLOT:    cfg_next.write_slot_time  = wr_data;
                REG_READ_SAMPLE:   cfg_next.read_sample_time = wr_data;
                REG_READ_SLOT:     cfg_next.read_slot_time   = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time   <= 10'd480;
            cfg_reg.presence_wait    <= 10'd70;
            cfg_reg.reset_tail       <= 10'd410;
            cfg_reg.one_low_time     <= 10'd10;
            cfg_reg.zero_low_time    <= 10'd60;
            cfg_reg.write_slot_time  <= 10'd70;
            cfg_reg.read_sample_time <= 10'd15;
            cfg_reg.read_slot_time   <= 10'd80;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/owm_step.sv =====
// next bus state and result for one transaction of the one-wire bus master
module owm_step (
    input  owm_pkg::owm_cfg_t    cfg,
    input  owm_pkg::owm_state_t  state_cur,
    input  owm_pkg::owm_item_t   item,
    output owm_pkg::owm_state_t  state_upd,
    output owm_pkg::owm_result_t result
);
    import owm_pkg::*;

    logic [PHASE_W-1:0]  phase_cur;
    logic                busy;
    logic                done;
    logic                rej;
    logic                drive;
    logic [TIMER_W-1:0]  t_inc;
    logic [BITCNT_W-1:0] bc_inc;
    logic [BYTE_W-1:0]   rd_shift;
    cfg_word_t           slot_eff;
    cfg_word_t           samp_eff;
    cfg_word_t           low_eff;
    owm_state_t          s;

    always_comb
    begin
        phase_cur = (state_cur.phase > PH_READ) ? PH_IDLE : state_cur.phase;
        busy      = (phase_cur != PH_IDLE);
        done      = 1'b0;
        rej       = 1'b0;
        s         = state_cur;
        s.phase   = phase_cur;
        t_inc     = (state_cur.slot_timer < TIMER_MAX) ? state_cur.slot_timer + 11'd1
                                                        : state_cur.slot_timer;
        bc_inc    = state_cur.bit_count + 4'd1;
        slot_eff  = eff(cfg.read_slot_time);
        samp_eff  = eff(cfg.read_sample_time);
        if (samp_eff > slot_eff)
        begin
            samp_eff = slot_eff;
        end
        rd_shift  = {item.line_level, state_cur.shift_byte[BYTE_W-1:1]};

        if (item.action != ACT_TICK)
        begin
            if (busy)
            begin
                rej = 1'b1;
            end
            else
            begin
                s.slot_timer = '0;
                s.bit_count  = '0;
                case (item.action)
                    ACT_RESET:
                    begin
                        s.phase = PH_RLOW;
                    end
                    ACT_WRITE:
                    begin
                        s.phase      = PH_WRITE;
                        s.shift_byte = item.write_byte;
                    end
                    default:
                    begin
                        s.phase      = PH_READ;
                        s.shift_byte = '0;
                    end
                endcase
            end
        end
        else if (busy)
        begin
            s.slot_timer = t_inc;
            case (phase_cur)
                PH_RLOW:
                begin
                    if (t_inc >= {1'b0, eff(cfg.reset_low_time)})
                    begin
                        s.phase      = PH_RWAIT;
                        s.slot_timer = '0;
                    end
                end
                PH_RWAIT:
                begin
                    if (t_inc >= {1'b0, eff(cfg.presence_wait)})
                    begin
                        s.presence_seen = ~item.line_level;
                        s.phase         = PH_RTAIL;
                        s.slot_timer    = '0;
                    end
                end
                PH_RTAIL:
                begin
                    if (t_inc >= {1'b0, eff(cfg.reset_tail)})
                    begin
                        s.phase = PH_IDLE;
                        done    = 1'b1;
                    end
                end
                PH_WRITE:
                begin
                    if (t_inc >= {1'b0, eff(cfg.write_slot_time)})
                    begin
                        s.shift_byte = {1'b0, state_cur.shift_byte[BYTE_W-1:1]};
                        s.bit_count  = bc_inc;
                        if (bc_inc >= BITS_PER_TRANSFER)
                        begin
                            s.phase = PH_IDLE;
                            done    = 1'b1;
                        end
                        else
                        begin
                            s.slot_timer = '0;
                        end
                    end
                end
                default:
                begin
                    if (t_inc == {1'b0, samp_eff})
                    begin
                        s.shift_byte = rd_shift;
                    end
                    if (t_inc >= {1'b0, slot_eff})
                    begin
                        s.bit_count = bc_inc;
                        if (bc_inc >= BITS_PER_TRANSFER)
                        begin
                            s.read_hold = s.shift_byte;
                            s.phase     = PH_IDLE;
                            done        = 1'b1;
                        end
                        else
                        begin
                            s.slot_timer = '0;
                        end
                    end
                end
            endcase
        end

        low_eff = s.shift_byte[0] ? eff(cfg.one_low_time) : eff(cfg.zero_low_time);
        case (s.phase)
            PH_RLOW:  drive = 1'b1;
            PH_WRITE: drive = (s.slot_timer < {1'b0, low_eff});
            PH_READ:  drive = (s.slot_timer < READ_LOW_TICKS);
            default:  drive = 1'b0;
        endcase
    end

    assign state_upd         = s;
    assign result.drive_low  = drive;
    assign result.busy_res   = (s.phase != PH_IDLE);
    assign result.done_res   = done;
    assign result.read_value = s.read_hold;
    assign result.presence   = s.presence_seen;
    assign result.rejected   = rej;

endmodule

// ===== design/one_wire_bus_master_top.sv =====
// top level of the one-wire bus master: input register, bus state and result register
// Each transaction on the slave side is one microsecond tick or a command (reset pulse,
// write byte, read byte) and yields exactly one result transaction on the master side,
// giving the bus drive and status after that item. It takes one item per clock while the
// master side does not stall; the bus state update works on the item while it sits in the
// input register, and its result is loaded into the result register when that register
// is empty or being taken, then shown on the master side. Backpressure on the master
// side holds the pipeline without losing items. Timing registers are written through
// the cfg port and should only change while no transaction is in flight.
module one_wire_bus_master_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // write_byte [7:0], line_level [8], zero fill
    input  logic [owm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // action [1:0]
    input  logic [owm_pkg::ACTION_W-1:0]     s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // drive_low [0], busy_res [1], done_res [2], read_value [10:3], presence [11],
    // rejected [12], zero fill
    output logic [owm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [owm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  owm_pkg::cfg_word_t               cfg_data
);
    import owm_pkg::*;

    owm_cfg_t    cfg;
    owm_item_t   item_reg;
    logic        in_valid_reg;
    owm_state_t  state_reg;
    owm_state_t  state_next;
    owm_result_t res_next;
    owm_result_t res_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        s_accept;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    owm_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    owm_step u_step (
        .cfg       (cfg),
        .state_cur (state_reg),
        .item      (item_reg),
        .state_upd (state_next),
        .result    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.action     <= s_axis_tuser;
            item_reg.write_byte <= s_axis_tdata[7:0];
            item_reg.line_level <= s_axis_tdata[8];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, res_reg.rejected, res_reg.presence, res_reg.read_value,
                            res_reg.done_res, res_reg.busy_res, res_reg.drive_low};

endmodule

// ===== test/one_wire_bus_master_top_tb.sv =====
// self-checking testbench for the one-wire bus master: directed and random streams
`timescale 1ns / 1ps

module one_wire_bus_master_top_tb;

    import owm_pkg::*;

    localparam int LINE_LOW     = 0;
    localparam int LINE_HIGH    = 1;
    localparam int LINE_RANDOM  = 2;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 400;
    localparam int PRINT_CAP    = 200;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [ACTION_W-1:0]    s_axis_tuser = ACT_TICK;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_RESET_LOW;
    cfg_word_t              cfg_data = '0;

    // bus model state and its copy of the timing registers
    owm_state_t  bus = '0;
    cfg_word_t   timing_regs [8] = '{10'd480, 10'd70, 10'd410, 10'd10,
                                     10'd60, 10'd70, 10'd15, 10'd80};
    cfg_word_t   next_timing [8];
    owm_result_t pending_status [$];

    bit          idle_on = 1'b1;
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned live_items = 0;
    int unsigned results_checked = 0;
    int unsigned ops_done = 0;
    int unsigned turned_away = 0;
    int unsigned timing_settings = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    one_wire_bus_master_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [TIMER_W-1:0] tick_count(input logic [CFG_IDX_W-1:0] idx);
        logic [TIMER_W-1:0] v;
        v = TIMER_W'(timing_regs[idx]);
        if (v == '0)
            v = TIMER_W'(1);
        return v;
    endfunction

    function automatic owm_result_t advance_bus(input owm_item_t it);
        owm_result_t        r;
        logic [TIMER_W-1:0] slot_len;
        logic [TIMER_W-1:0] samp_at;
        logic [TIMER_W-1:0] low_len;
        r = '0;
        if (bus.phase > PH_READ)
            bus.phase = PH_IDLE;
        if (it.action != ACT_TICK)
        begin
            if (bus.phase != PH_IDLE)
                r.rejected = 1'b1;
            else
            begin
                bus.slot_timer = '0;
                bus.bit_count  = '0;
                case (it.action)
                    ACT_RESET:
                        bus.phase = PH_RLOW;
                    ACT_WRITE:
                    begin
                        bus.phase      = PH_WRITE;
                        bus.shift_byte = it.write_byte;
                    end
                    default:
                    begin
                        bus.phase      = PH_READ;
                        bus.shift_byte = '0;
                    end
                endcase
            end
        end
        else if (bus.phase != PH_IDLE)
        begin
            if (bus.slot_timer != TIMER_MAX)
                bus.slot_timer = bus.slot_timer + 1'b1;
            case (bus.phase)
                PH_RLOW:
                    if (bus.slot_timer >= tick_count(REG_RESET_LOW))
                    begin
                        bus.phase      = PH_RWAIT;
                        bus.slot_timer = '0;
                    end
                PH_RWAIT:
                    if (bus.slot_timer >= tick_count(REG_PRESENCE_WAIT))
                    begin
                        bus.presence_seen = ~it.line_level;
                        bus.phase         = PH_RTAIL;
                        bus.slot_timer    = '0;
                    end
                PH_RTAIL:
                    if (bus.slot_timer >= tick_count(REG_RESET_TAIL))
                    begin
                        bus.phase  = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                PH_WRITE:
                    if (bus.slot_timer >= tick_count(REG_WRITE_SLOT))
                    begin
                        bus.shift_byte = bus.shift_byte >> 1;
                        bus.bit_count  = bus.bit_count + 1'b1;
                        if (bus.bit_count >= BITS_PER_TRANSFER)
                        begin
                            bus.phase  = PH_IDLE;
                            r.done_res = 1'b1;
                        end
                        else
                            bus.slot_timer = '0;
                    end
                default:
                begin
                    slot_len = tick_count(REG_READ_SLOT);
                    samp_at  = tick_count(REG_READ_SAMPLE);
                    if (samp_at > slot_len)
                        samp_at = slot_len;
                    if (bus.slot_timer == samp_at)
                        bus.shift_byte = {it.line_level, bus.shift_byte[BYTE_W-1:1]};
                    if (bus.slot_timer >= slot_len)
                    begin
                        bus.bit_count = bus.bit_count + 1'b1;
                        if (bus.bit_count >= BITS_PER_TRANSFER)
                        begin
                            bus.read_hold = bus.shift_byte;
                            bus.phase     = PH_IDLE;
                            r.done_res    = 1'b1;
                        end
                        else
                            bus.slot_timer = '0;
                    end
                end
            endcase
        end

        case (bus.phase)
            PH_RLOW:
                r.drive_low = 1'b1;
            PH_WRITE:
            begin
                low_len = bus.shift_byte[0] ? tick_count(REG_ONE_LOW)
                                            : tick_count(REG_ZERO_LOW);
                r.drive_low = (bus.slot_timer < low_len);
            end
            PH_READ:
                r.drive_low = (bus.slot_timer < READ_LOW_TICKS);
            default:
                r.drive_low = 1'b0;
        endcase
        r.busy_res   = (bus.phase != PH_IDLE);
        r.read_value = bus.read_hold;
        r.presence   = bus.presence_seen;
        return r;
    endfunction

    function automatic logic [ACTION_W-1:0] any_command();
        case ($urandom_range(0, 2))
            0:       return ACT_RESET;
            1:       return ACT_WRITE;
            default: return ACT_READ;
        endcase
    endfunction

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] data_b,
                             input logic lvl);
        owm_item_t it;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(IN_TDATA_W-BYTE_W-1){1'b0}}, lvl, data_b};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        it.action     = act;
        it.write_byte = data_b;
        it.line_level = lvl;
        if (act != ACT_TICK || bus.phase != PH_IDLE)
            live_items++;
        pending_status.push_back(advance_bus(it));
        items_sent++;
    endtask

    task automatic tick_until_idle(input int lvl_mode, input bit noisy);
        logic lvl;
        while (bus.phase != PH_IDLE)
        begin
            if (lvl_mode == LINE_RANDOM)
                lvl = 1'($urandom_range(0, 1));
            else
                lvl = (lvl_mode == LINE_HIGH);
            if (noisy && $urandom_range(0, 30) == 0)
                send_item(any_command(), BYTE_W'($urandom), lvl);
            else
                send_item(ACT_TICK, BYTE_W'($urandom), lvl);
        end
    endtask

    task automatic tick_n(input int n, input int lvl_mode);
        logic lvl;
        for (int i = 0; i < n; i++)
        begin
            if (lvl_mode == LINE_RANDOM)
                lvl = 1'($urandom_range(0, 1));
            else
                lvl = (lvl_mode == LINE_HIGH);
            send_item(ACT_TICK, BYTE_W'($urandom), lvl);
        end
    endtask

    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_timing();
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= next_timing[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            timing_regs[i] = next_timing[i];
        end
        cfg_valid <= 1'b0;
        timing_settings++;
    endtask

    // rewrite one timing register, the others keep their values
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t val);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        timing_regs[idx] = val;
        cfg_valid <= 1'b0;
        timing_settings++;
    endtask

    task automatic retime(input cfg_word_t t0, input cfg_word_t t1, input cfg_word_t t2,
                          input cfg_word_t t3, input cfg_word_t t4, input cfg_word_t t5,
                          input cfg_word_t t6, input cfg_word_t t7);
        next_timing = '{t0, t1, t2, t3, t4, t5, t6, t7};
        quiesce();
        load_timing();
    endtask

    task automatic one_of_each(input int lvl_mode);
        send_item(ACT_RESET, BYTE_W'($urandom), 1'b1);
        tick_until_idle(lvl_mode, 1'b0);
        send_item(ACT_WRITE, BYTE_W'($urandom), 1'b0);
        tick_until_idle(lvl_mode, 1'b0);
        send_item(ACT_READ, BYTE_W'($urandom), 1'b1);
        tick_until_idle(lvl_mode, 1'b0);
    endtask

    // start under long timing, then finish the operation under short timing
    task automatic long_then_short(input logic [ACTION_W-1:0] act);
        retime(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1, 10'd1023, 10'd1, 10'd1023);
        send_item(act, BYTE_W'($urandom), 1'b1);
        tick_n(30, LINE_RANDOM);
        retime(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd2, 10'd1, 10'd2);
        tick_until_idle(LINE_RANDOM, 1'b0);
    endtask

    // starts with the timing registers at their power-up values
    task automatic test_reset_values();
        send_item(ACT_TICK, 8'h00, 1'b0);
        send_item(ACT_TICK, 8'hFF, 1'b1);
        // a one slot then a zero slot
        send_item(ACT_WRITE, 8'h01, 1'b0);
        tick_n(145, LINE_RANDOM);
        send_item(ACT_READ, 8'hC3, 1'b1);
        set_reg(REG_WRITE_SLOT, 10'd2);
        tick_until_idle(LINE_RANDOM, 1'b0);
        // first read slot
        send_item(ACT_READ, 8'h00, 1'b0);
        tick_n(85, LINE_RANDOM);
        set_reg(REG_READ_SLOT, 10'd2);
        tick_until_idle(LINE_RANDOM, 1'b0);
        // reset pulse and presence sample
        send_item(ACT_RESET, 8'h00, 1'b1);
        tick_n(560, LINE_LOW);
        send_item(ACT_WRITE, 8'h3C, 1'b0);
        set_reg(REG_RESET_TAIL, 10'd1);
        tick_until_idle(LINE_LOW, 1'b0);
    endtask

    task automatic test_basic_ops();
        retime(10'd3, 10'd2, 10'd2, 10'd2, 10'd4, 10'd5, 10'd3, 10'd5);
        send_item(ACT_TICK, 8'h55, 1'b1);
        send_item(ACT_RESET, 8'h00, 1'b1);
        send_item(ACT_RESET, 8'hFF, 1'b0);
        tick_until_idle(LINE_HIGH, 1'b0);
        send_item(ACT_RESET, 8'h00, 1'b0);
        tick_until_idle(LINE_LOW, 1'b0);
        send_item(ACT_WRITE, 8'h00, 1'b1);
        send_item(ACT_WRITE, 8'h81, 1'b1);
        tick_until_idle(LINE_RANDOM, 1'b0);
        send_item(ACT_WRITE, 8'hFF, 1'b0);
        tick_until_idle(LINE_RANDOM, 1'b0);
        send_item(ACT_READ, 8'h00, 1'b1);
        send_item(ACT_READ, 8'hFF, 1'b0);
        tick_until_idle(LINE_HIGH, 1'b0);
        send_item(ACT_READ, 8'h00, 1'b1);
        tick_until_idle(LINE_LOW, 1'b0);
        send_item(ACT_READ, 8'h00, 1'b1);
        tick_until_idle(LINE_RANDOM, 1'b0);
    endtask

    task automatic test_timing_corners();
        // zero registers behave as one tick
        retime('0, '0, '0, '0, '0, '0, '0, '0);
        one_of_each(LINE_RANDOM);
        // low pulse longer than the slot, sample point beyond the slot
        retime(10'd1, 10'd1, 10'd1, 10'd9, 10'd1023, 10'd4, 10'd1023, 10'd3);
        send_item(ACT_WRITE, 8'h5A, 1'b0);
        tick_until_idle(LINE_RANDOM, 1'b0);
        send_item(ACT_READ, 8'h00, 1'b0);
        tick_until_idle(LINE_RANDOM, 1'b0);
        // sample on the last tick of the slot
        retime(10'd2, 10'd3, 10'd1, 10'd1, 10'd2, 10'd6, 10'd6, 10'd6);
        send_item(ACT_READ, 8'h00, 1'b0);
        tick_until_idle(LINE_RANDOM, 1'b0);
        // smallest legal values
        retime(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd2, 10'd1, 10'd2);
        one_of_each(LINE_RANDOM);
        // largest values in all registers but zero low and read sample
        long_then_short(ACT_RESET);
        long_then_short(ACT_WRITE);
        long_then_short(ACT_READ);
    endtask

    task automatic test_random_traffic();
        int unsigned start_items;
        start_items = live_items;
        while (live_items - start_items < RANDOM_ITEMS)
        begin
            quiesce();
            idle_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 8; i++)
                next_timing[i] = ($urandom_range(0, 9) == 0) ? '0
                                 : cfg_word_t'($urandom_range(1, 12));
            load_timing();
            repeat ($urandom_range(3, 6))
            begin
                if ($urandom_range(0, 5) == 0)
                    send_item(ACT_TICK, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
                send_item(any_command(), BYTE_W'($urandom), 1'($urandom_range(0, 1)));
                tick_until_idle(LINE_RANDOM, 1'b1);
            end
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        retime(10'd2, 10'd2, 10'd2, 10'd1, 10'd3, 10'd4, 10'd2, 10'd4);
        repeat (6)
        begin
            send_item(any_command(), BYTE_W'($urandom), 1'($urandom_range(0, 1)));
            tick_until_idle(LINE_RANDOM, 1'b1);
        end
    endtask

    task automatic compare_field(input string field, input int unsigned want_v,
                                 input int unsigned got_v);
        if (want_v != got_v)
        begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, field, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        owm_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_status.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= PRINT_CAP)
                    $display("%0t: unexpected result transaction, expected none actual %0h",
                             $time, m_axis_tdata);
            end
            else
            begin
                want = pending_status.pop_front();
                results_checked++;
                compare_field("drive_low", want.drive_low, m_axis_tdata[0]);
                compare_field("busy", want.busy_res, m_axis_tdata[1]);
                compare_field("done", want.done_res, m_axis_tdata[2]);
                compare_field("read_value", want.read_value, m_axis_tdata[10:3]);
                compare_field("presence", want.presence, m_axis_tdata[11]);
                compare_field("rejected", want.rejected, m_axis_tdata[12]);
                if (want.done_res)
                    ops_done++;
                if (want.rejected)
                    turned_away++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 11) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 12);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, pending_status.size());
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_basic_ops();
        test_timing_corners();
        test_random_traffic();
        test_back_to_back();
        quiesce();
        $display("covered %0d items (%0d active) under %0d timing settings",
                 items_sent, live_items, timing_settings);
        $display("checked %0d results: %0d operations completed, %0d busy commands refused",
                 results_checked, ops_done, turned_away);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
